FILE: sv/lts_pkg.sv
package lts_pkg;

	localparam int LEXEME_MAX = 50;
	localparam int DIGITS_MAX = 20;
	localparam int KEYWORD_MAX_LEN = 8;
	localparam int KEYWORD_COUNT = 28;
	localparam int QUEUE_DEPTH = 4;
	localparam int QUEUE_AW = $clog2(QUEUE_DEPTH);

	localparam logic [30:0] ACC_MAX = 31'h7FFF_FFFF;
	localparam logic [15:0] LINE_MAX = 16'hFFFF;

	typedef enum logic [1:0] {
		KIND_ECHO,
		KIND_TOKEN,
		KIND_ERROR
	} kind_t;

	typedef enum logic [3:0] {
		CLS_KEYWORD,
		CLS_IDENT,
		CLS_INT,
		CLS_REAL,
		CLS_CHAR,
		CLS_LITERAL,
		CLS_ARITH,
		CLS_RELAT,
		CLS_LOGIC,
		CLS_SIGN,
		CLS_END
	} class_t;

	typedef enum logic [4:0] {
		ST_START,
		ST_IDENT,
		ST_INT,
		ST_REAL,
		ST_CHAR_OPEN,
		ST_CHAR_ESC,
		ST_CHAR_CLOSE,
		ST_STRING,
		ST_SLASH,
		ST_COMMENT,
		ST_EQ,
		ST_BANG,
		ST_LT,
		ST_GT,
		ST_AMP,
		ST_BAR
	} scan_state_t;

	localparam logic [4:0] OP_PLUS = 5'd0;
	localparam logic [4:0] OP_MINUS = 5'd1;
	localparam logic [4:0] OP_TIMES = 5'd2;
	localparam logic [4:0] OP_DIV = 5'd3;
	localparam logic [4:0] OP_ASSIGN = 5'd4;
	localparam logic [4:0] REL_EQ = 5'd0;
	localparam logic [4:0] REL_NE = 5'd1;
	localparam logic [4:0] REL_LT = 5'd2;
	localparam logic [4:0] REL_LE = 5'd3;
	localparam logic [4:0] REL_GT = 5'd4;
	localparam logic [4:0] REL_GE = 5'd5;
	localparam logic [4:0] LOG_NOT = 5'd0;
	localparam logic [4:0] LOG_AND = 5'd1;
	localparam logic [4:0] LOG_OR = 5'd2;
	localparam logic [4:0] SGN_LBRACE = 5'd0;
	localparam logic [4:0] SGN_RBRACE = 5'd1;
	localparam logic [4:0] SGN_LPAREN = 5'd2;
	localparam logic [4:0] SGN_RPAREN = 5'd3;
	localparam logic [4:0] SGN_COMMA = 5'd4;
	localparam logic [4:0] SGN_LBRACK = 5'd5;
	localparam logic [4:0] SGN_RBRACK = 5'd6;
	localparam logic [4:0] SGN_AMP = 5'd7;
	localparam logic [4:0] CODE_NONE = 5'd0;

	localparam logic [63:0] KW_TAB [KEYWORD_COUNT] = '{
		"main", "block", "endblock", "const", "char", "int", "real", "bool",
		"with", "do", "varying", "from", "to", "downto", "while", "endwhile",
		"for", "if", "elseif", "else", "endif", "goback", "getint", "getreal",
		"getchar", "putint", "putreal", "putchar"
	};

	typedef struct packed {
		kind_t kind;
		class_t token_class;
		logic [4:0] token_code;
		logic [30:0] int_value;
		logic [7:0] char_value;
		logic [15:0] line_number;
		logic last;
	} result_t;

	typedef struct packed {
		logic [1:0] cnt;
		result_t first;
		result_t second;
	} push_t;

	function automatic result_t mk_result(input kind_t k, input class_t c,
			input logic [4:0] code, input logic [30:0] v, input logic [7:0] ch,
			input logic [15:0] line);
		result_t r;
		r.kind = k;
		r.token_class = c;
		r.token_code = code;
		r.int_value = v;
		r.char_value = ch;
		r.line_number = line;
		r.last = 1'b0;
		return r;
	endfunction

	function automatic logic is_alpha(input logic [7:0] c);
		return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
	endfunction

	function automatic logic is_digit(input logic [7:0] c);
		return c >= "0" && c <= "9";
	endfunction

	function automatic logic is_print(input logic [7:0] c);
		return c >= 8'h20 && c <= 8'h7E;
	endfunction

	// returns {hit, keyword code}
	function automatic logic [5:0] kw_lookup(input logic [63:0] pre, input logic [5:0] len);
		logic [63:0] cand;
		logic [5:0] res;
		cand = '0;
		res = '0;
		for (int i = 0; i < KEYWORD_MAX_LEN; i++) begin
			if (i < int'(len))
				cand = {cand[55:0], pre[8*i +: 8]};
		end
		if (len <= 6'(KEYWORD_MAX_LEN)) begin
			for (int k = 0; k < KEYWORD_COUNT; k++) begin
				if (cand == KW_TAB[k])
					res = {1'b1, 5'(k)};
			end
		end
		return res;
	endfunction

endpackage

FILE: sv/lts_in_if.sv
interface lts_in_if;
	logic valid;
	logic ready;
	logic [7:0] char_code;
	logic end_of_file;

	modport source(output valid, char_code, end_of_file, input ready);
	modport sink(input valid, char_code, end_of_file, output ready);
endinterface

FILE: sv/lts_out_if.sv
interface lts_out_if;
	logic valid;
	logic ready;
	logic [1:0] kind;
	logic [3:0] token_class;
	logic [4:0] token_code;
	logic [30:0] int_value;
	logic [7:0] char_value;
	logic [15:0] line_number;
	logic last;

	modport source(output valid, kind, token_class, token_code, int_value, char_value,
		line_number, last, input ready);
	modport sink(input valid, kind, token_class, token_code, int_value, char_value,
		line_number, last, output ready);
endinterface

FILE: sv/lts_scanner.sv
module lts_scanner
	import lts_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic take,
	input logic [7:0] char_code,
	input logic end_of_file,
	output push_t push
);

	scan_state_t st_q, st_d;
	logic [15:0] line_q, line_d;
	logic [63:0] pre_q, pre_d;
	logic [5:0] len_q, len_d;
	logic [4:0] dig_q, dig_d;
	logic [30:0] acc_q, acc_d;
	logic [7:0] held_q, held_d;

	result_t res [2];
	logic [1:0] n;
	logic rescan;
	logic eof;
	logic [7:0] c;
	logic is_eq;
	logic [34:0] prod;
	logic [5:0] kw;

	assign eof = end_of_file;
	assign c = char_code;
	assign is_eq = !eof && c == "=";
	assign prod = 35'(acc_q) * 35'd10 + 35'(c - "0");
	assign kw = kw_lookup(pre_q, len_q);

	always_comb begin
		st_d = st_q;
		line_d = line_q;
		pre_d = pre_q;
		len_d = len_q;
		dig_d = dig_q;
		acc_d = acc_q;
		held_d = held_q;
		res[0] = mk_result(KIND_ECHO, CLS_KEYWORD, CODE_NONE, '0, '0, line_q);
		res[1] = res[0];
		n = 2'd0;
		rescan = 1'b0;

		case (st_q)
			ST_IDENT: begin
				if (!eof && (c == "_" || is_alpha(c) || is_digit(c))) begin
					if (len_q < 6'(KEYWORD_MAX_LEN))
						pre_d[{len_q[2:0], 3'b000} +: 8] = c;
					if (len_q < 6'(LEXEME_MAX))
						len_d = len_q + 6'd1;
					res[n[0]] = mk_result(KIND_ECHO, CLS_KEYWORD, CODE_NONE, '0, c, line_d);
					n = n + 2'd1;
				end else begin
					if (kw[5])
						res[n[0]] = mk_result(KIND_TOKEN, CLS_KEYWORD, kw[4:0], '0, '0, line_d);
					else
						res[n[0]] = mk_result(KIND_TOKEN, CLS_IDENT, CODE_NONE, '0, '0, line_d);
					n = n + 2'd1;
					rescan = 1'b1;
				end
			end
			ST_INT: begin
				if (!eof && is_digit(c)) begin
					acc_d = (prod > 35'(ACC_MAX)) ? ACC_MAX : prod[30:0];
					if (dig_q < 5'(DIGITS_MAX))
						dig_d = dig_q + 5'd1;
					res[n[0]] = mk_result(KIND_ECHO, CLS_KEYWORD, CODE_NONE, '0, c, line_d);
					n = n + 2'd1;
				end else if (!eof && c == ".") begin
					st_d = ST_REAL;
					res[n[0]] = mk_result(KIND_ECHO, CLS_KEYWORD, CODE_NONE, '0, c, line_d);
					n = n + 2'd1;
				end else if (!eof && (c == "_" || is_alpha(c))) begin
					res[n[0]] = mk_result(KIND_ERROR, CLS_KEYWORD, CODE_NONE, '0, c, line_d);
					n = n + 2'd1;
					st_d = ST_START;
				end else begin
					res[n[0]] = mk_result(KIND_TOKEN, CLS_INT, CODE_NONE, acc_q, '0, line_d);
					n = n + 2'd1;
					rescan = 1'b1;
				end
			end
			ST_REAL: begin
				if (!eof && is_digit(c)) begin
					if (dig_q < 5'(DIGITS_MAX))
						dig_d = dig_q + 5'd1;
					res[n[0]] = mk_result(KIND_ECHO, CLS_KEYWORD, CODE_NONE, '0, c, line_d);
					n = n + 2'd1;
				end else begin
					res[n[0]] = mk_result(KIND_TOKEN, CLS_REAL, CODE_NONE, '0, '0, line_d);
					n = n + 2'd1;
					rescan = 1'b1;
				end
			end
			ST_CHAR_OPEN: begin
				if (eof || c == 8'h27 || (c != 8'h5C && !is_print(c))) begin
					res[n[0]] = mk_result(KIND_ERROR, CLS_KEYWORD, CODE_NONE, '0,
						eof ? 8'd0 : c, line_d);
					n = n + 2'd1;
					if (!eof && c == 8'h0A && line_d != LINE_MAX)
						line_d = line_d + 16'd1;
					st_d = ST_START;
				end else if (c == 8'h5C) begin
					st_d = ST_CHAR_ESC;
				end else begin
					held_d = c;
					st_d = ST_CHAR_CLOSE;
				end
			end
			ST_CHAR_ESC: begin
				if (!eof && (c == "n" || c == "0")) begin
					held_d = (c == "n") ? 8'd10 : 8'd0;
					st_d = ST_CHAR_CLOSE;
				end else begin
					res[n[0]] = mk_result(KIND_ERROR, CLS_KEYWORD, CODE_NONE, '0,
						eof ? 8'd0 : c, line_d);
					n = n + 2'd1;
					if (!eof && c == 8'h0A && line_d != LINE_MAX)
						line_d = line_d + 16'd1;
					st_d = ST_START;
				end
			end
			ST_CHAR_CLOSE: begin
				if (!eof && c == 8'h27) begin
					res[n[0]] = mk_result(KIND_TOKEN, CLS_CHAR, CODE_NONE, '0, held_q, line_d);
					n = n + 2'd1;
				end else begin
					res[n[0]] = mk_result(KIND_ERROR, CLS_KEYWORD, CODE_NONE, '0,
						eof ? 8'd0 : c, line_d);
					n = n + 2'd1;
					if (!eof && c == 8'h0A && line_d != LINE_MAX)
						line_d = line_d + 16'd1;
				end
				st_d = ST_START;
			end
			ST_STRING: begin
				if (eof || c == 8'h0A) begin
					res[n[0]] = mk_result(KIND_ERROR, CLS_KEYWORD, CODE_NONE, '0,
						eof ? 8'd0 : c, line_d);
					n = n + 2'd1;
					if (!eof && line_d != LINE_MAX)
						line_d = line_d + 16'd1;
					st_d = ST_START;
				end else if (c == 8'h22) begin
					if (len_q == 6'd0)
						res[n[0]] = mk_result(KIND_ERROR, CLS_KEYWORD, CODE_NONE, '0, c, line_d);
					else
						res[n[0]] = mk_result(KIND_TOKEN, CLS_LITERAL, CODE_NONE, '0, '0, line_d);
					n = n + 2'd1;
					st_d = ST_START;
				end else if (is_print(c)) begin
					if (len_q < 6'(LEXEME_MAX - 1)) begin
						len_d = len_q + 6'd1;
						res[n[0]] = mk_result(KIND_ECHO, CLS_KEYWORD, CODE_NONE, '0, c, line_d);
					end else begin
						res[n[0]] = mk_result(KIND_ERROR, CLS_KEYWORD, CODE_NONE, '0, c, line_d);
						st_d = ST_START;
					end
					n = n + 2'd1;
				end
			end
			ST_SLASH: begin
				if (!eof && c == "/") begin
					st_d = ST_COMMENT;
				end else begin
					res[n[0]] = mk_result(KIND_TOKEN, CLS_ARITH, OP_DIV, '0, '0, line_d);
					n = n + 2'd1;
					rescan = 1'b1;
				end
			end
			ST_COMMENT: begin
				if (eof) begin
					rescan = 1'b1;
				end else if (c == 8'h0A) begin
					if (line_d != LINE_MAX)
						line_d = line_d + 16'd1;
					st_d = ST_START;
				end
			end
			ST_EQ: begin
				if (is_eq) begin
					res[n[0]] = mk_result(KIND_TOKEN, CLS_RELAT, REL_EQ, '0, '0, line_d);
				end else begin
					res[n[0]] = mk_result(KIND_TOKEN, CLS_ARITH, OP_ASSIGN, '0, '0, line_d);
					rescan = 1'b1;
				end
				n = n + 2'd1;
				st_d = ST_START;
			end
			ST_BANG: begin
				if (is_eq) begin
					res[n[0]] = mk_result(KIND_TOKEN, CLS_RELAT, REL_NE, '0, '0, line_d);
				end else begin
					res[n[0]] = mk_result(KIND_TOKEN, CLS_LOGIC, LOG_NOT, '0, '0, line_d);
					rescan = 1'b1;
				end
				n = n + 2'd1;
				st_d = ST_START;
			end
			ST_LT: begin
				res[n[0]] = mk_result(KIND_TOKEN, CLS_RELAT, is_eq ? REL_LE : REL_LT,
					'0, '0, line_d);
				n = n + 2'd1;
				rescan = !is_eq;
				st_d = ST_START;
			end
			ST_GT: begin
				res[n[0]] = mk_result(KIND_TOKEN, CLS_RELAT, is_eq ? REL_GE : REL_GT,
					'0, '0, line_d);
				n = n + 2'd1;
				rescan = !is_eq;
				st_d = ST_START;
			end
			ST_AMP: begin
				if (!eof && c == "&") begin
					res[n[0]] = mk_result(KIND_TOKEN, CLS_LOGIC, LOG_AND, '0, '0, line_d);
				end else begin
					res[n[0]] = mk_result(KIND_TOKEN, CLS_SIGN, SGN_AMP, '0, '0, line_d);
					rescan = 1'b1;
				end
				n = n + 2'd1;
				st_d = ST_START;
			end
			ST_BAR: begin
				if (!eof && c == "|")
					res[n[0]] = mk_result(KIND_TOKEN, CLS_LOGIC, LOG_OR, '0, '0, line_d);
				else
					res[n[0]] = mk_result(KIND_ERROR, CLS_KEYWORD, CODE_NONE, '0,
						eof ? 8'd0 : c, line_d);
				n = n + 2'd1;
				if (!eof && c == 8'h0A && line_d != LINE_MAX)
					line_d = line_d + 16'd1;
				st_d = ST_START;
			end
			default: begin
				rescan = 1'b1;
			end
		endcase

		if (rescan) begin
			st_d = ST_START;
			if (eof) begin
				res[n[0]] = mk_result(KIND_TOKEN, CLS_END, CODE_NONE, '0, '0, line_d);
				n = n + 2'd1;
				line_d = 16'd1;
			end else if (c == "_" || is_alpha(c)) begin
				pre_d[7:0] = c;
				len_d = 6'd1;
				st_d = ST_IDENT;
				res[n[0]] = mk_result(KIND_ECHO, CLS_KEYWORD, CODE_NONE, '0, c, line_d);
				n = n + 2'd1;
			end else if (is_digit(c)) begin
				acc_d = 31'(c - "0");
				dig_d = 5'd1;
				st_d = ST_INT;
				res[n[0]] = mk_result(KIND_ECHO, CLS_KEYWORD, CODE_NONE, '0, c, line_d);
				n = n + 2'd1;
			end else begin
				case (c)
					" ", 8'h09: ;
					8'h0A: begin
						if (line_d != LINE_MAX)
							line_d = line_d + 16'd1;
					end
					8'h27: st_d = ST_CHAR_OPEN;
					8'h22: begin
						len_d = 6'd0;
						st_d = ST_STRING;
					end
					"/": st_d = ST_SLASH;
					"=": st_d = ST_EQ;
					"!": st_d = ST_BANG;
					"<": st_d = ST_LT;
					">": st_d = ST_GT;
					"&": st_d = ST_AMP;
					"|": st_d = ST_BAR;
					"+", "-", "*": begin
						res[n[0]] = mk_result(KIND_TOKEN, CLS_ARITH,
							(c == "+") ? OP_PLUS : (c == "-") ? OP_MINUS : OP_TIMES,
							'0, '0, line_d);
						n = n + 2'd1;
					end
					"{", "}", "(", ")", ",", "[", "]": begin
						res[n[0]] = mk_result(KIND_TOKEN, CLS_SIGN,
							(c == "{") ? SGN_LBRACE : (c == "}") ? SGN_RBRACE :
							(c == "(") ? SGN_LPAREN : (c == ")") ? SGN_RPAREN :
							(c == ",") ? SGN_COMMA : (c == "[") ? SGN_LBRACK : SGN_RBRACK,
							'0, '0, line_d);
						n = n + 2'd1;
					end
					default: begin
						res[n[0]] = mk_result(KIND_ERROR, CLS_KEYWORD, CODE_NONE, '0, c, line_d);
						n = n + 2'd1;
						if (c == 8'h0A && line_d != LINE_MAX)
							line_d = line_d + 16'd1;
					end
				endcase
			end
		end

		if (n == 2'd1)
			res[0].last = 1'b1;
		if (n == 2'd2)
			res[1].last = 1'b1;
	end

	assign push.cnt = n;
	assign push.first = res[0];
	assign push.second = res[1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_START;
			line_q <= 16'd1;
			len_q <= '0;
			dig_q <= '0;
			acc_q <= '0;
			held_q <= '0;
		end else if (take) begin
			st_q <= st_d;
			line_q <= line_d;
			len_q <= len_d;
			dig_q <= dig_d;
			acc_q <= acc_d;
			held_q <= held_d;
		end
	end

	always_ff @(posedge clk) begin
		if (take)
			pre_q <= pre_d;
	end

endmodule

FILE: sv/lts_result_queue.sv
module lts_result_queue
	import lts_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic push_en,
	input push_t push,
	output logic room,
	lts_out_if.source results
);

	result_t mem_q [QUEUE_DEPTH];
	logic [QUEUE_AW-1:0] wr_q, rd_q;
	logic [QUEUE_AW:0] count_q;
	logic pop;
	logic [1:0] added;
	result_t head;

	assign pop = results.valid && results.ready;
	assign added = push_en ? push.cnt : 2'd0;
	assign room = count_q <= (QUEUE_AW+1)'(QUEUE_DEPTH - 2);
	assign head = mem_q[rd_q];

	assign results.valid = count_q != '0;
	assign results.kind = head.kind;
	assign results.token_class = head.token_class;
	assign results.token_code = head.token_code;
	assign results.int_value = head.int_value;
	assign results.char_value = head.char_value;
	assign results.line_number = head.line_number;
	assign results.last = head.last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			count_q <= '0;
		end else begin
			wr_q <= wr_q + QUEUE_AW'(added);
			if (pop)
				rd_q <= rd_q + QUEUE_AW'(1);
			count_q <= count_q + (QUEUE_AW+1)'(added) - (QUEUE_AW+1)'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (added != 2'd0)
			mem_q[wr_q] <= push.first;
		if (added == 2'd2)
			mem_q[wr_q + QUEUE_AW'(1)] <= push.second;
	end

endmodule

FILE: sv/lexical_token_scanner.sv
// Lexical scanner: takes one source character (or end of file) per transfer and returns
// echoes of lexeme characters, tokens and errors, one per result transfer, with last
// set on the final result of each character. The character that ends a token is
// scanned again in the same cycle in which it is taken, so one character gives up to
// two results. Results wait in a four-entry queue; input is taken whenever the queue
// has room for two, so the input rate is one character per cycle, limited only by the
// output side draining one result per cycle.
module lexical_token_scanner
	import lts_pkg::*;
(
	input logic clk,
	input logic arst_n,
	lts_in_if.sink chars,
	lts_out_if.source results
);

	push_t push;
	logic room;
	logic take;

	assign chars.ready = room;
	assign take = chars.valid && room;

	lts_scanner u_scanner (
		.clk(clk),
		.arst_n(arst_n),
		.take(take),
		.char_code(chars.char_code),
		.end_of_file(chars.end_of_file),
		.push(push)
	);

	lts_result_queue u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push_en(take),
		.push(push),
		.room(room),
		.results(results)
	);

`ifndef SYNTHESIS
	a_eof_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		chars.valid && chars.ready && chars.end_of_file |=> results.valid)
		else $error("end of file transfer gave no result");

	a_eof_pushes: assert property (@(posedge clk) disable iff (!arst_n)
		take && chars.end_of_file |-> push.cnt != 2'd0)
		else $error("end of file produced empty push");

	a_push_bound: assert property (@(posedge clk) disable iff (!arst_n)
		push.cnt != 2'd3)
		else $error("more than two results for one character");
`endif

endmodule
